// ===== design/cpfm_pkg.sv =====
`timescale 1ns / 1ps

package cpfm_pkg;

  localparam int unsigned DATA_WIDTH      = 32;
  localparam int unsigned ACTION_WIDTH    = 2;
  localparam int unsigned CFG_INDEX_WIDTH = 1;
  localparam int unsigned STEP_WIDTH      = 5;

  localparam logic [DATA_WIDTH-1:0] CLOCK_HZ_RESET     = 32'd100000000;
  localparam logic [DATA_WIDTH-1:0] COUNTER_SPAN_RESET = 32'hFFFF_FFFF;
  localparam logic [STEP_WIDTH-1:0] LAST_STEP          = 5'd31;

  typedef enum logic [ACTION_WIDTH-1:0] {
    ACT_CAPTURE_A = 2'd0,
    ACT_CAPTURE_B = 2'd1,
    ACT_OVERFLOW  = 2'd2,
    ACT_UNUSED    = 2'd3
  } action_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_CLOCK_HZ     = 1'd0,
    REG_COUNTER_SPAN = 1'd1
  } reg_index_t;

  typedef struct packed {
    logic [ACTION_WIDTH-1:0] action;
    logic [DATA_WIDTH-1:0]   capture_value;
  } event_word_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] period_counts;
    logic [DATA_WIDTH-1:0] frequency;
    logic                  forward;
    logic                  divide_error;
  } result_word_t;

endpackage

// ===== design/capture_period_frequency_meter_unit.sv =====
`timescale 1ns / 1ps

// Capture period and frequency meter. Each accepted event word is a capture on
// channel A (forward), a capture on channel B (reverse) or a counter overflow.
// Overflows, first captures and unused codes give no result. A second capture
// gives one result word, formed in order by the overflow-tally times
// counter-span product, the period subtraction, the shift-subtract divider
// that forms clock_hz / period, and the hand-off to the output register. The
// event side stalls while a second capture is in work; the output register
// holds a finished word until it is taken, and the next event is accepted
// meanwhile. A zero period gives frequency 0 with divide_error set.
// Configuration writes go straight into the registers and are meant for an
// idle block.
module capture_period_frequency_meter_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  event_valid,
  output logic                                  event_stall,
  input  cpfm_pkg::event_word_t                 event_word,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output cpfm_pkg::result_word_t                result_word,
  input  logic                                  cfg_write,
  input  logic [cpfm_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [cpfm_pkg::DATA_WIDTH-1:0]       cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_SUB  = 5'b00100,
    S_DIV  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state;

  logic [cpfm_pkg::DATA_WIDTH-1:0] clock_hz;
  logic [cpfm_pkg::DATA_WIDTH-1:0] counter_span;
  logic [cpfm_pkg::DATA_WIDTH-1:0] first_capture;
  logic                            awaiting_second;
  logic [cpfm_pkg::DATA_WIDTH-1:0] overflow_tally;

  logic [cpfm_pkg::DATA_WIDTH-1:0] second_capture;
  logic                            forward;
  logic [cpfm_pkg::DATA_WIDTH-1:0] span_product;
  logic [cpfm_pkg::DATA_WIDTH-1:0] period;
  logic [cpfm_pkg::DATA_WIDTH-1:0] remainder;
  logic [cpfm_pkg::DATA_WIDTH-1:0] quotient;
  logic [cpfm_pkg::STEP_WIDTH-1:0] step;

  logic                            accept;
  logic                            load;
  logic                            is_capture;
  logic [2*cpfm_pkg::DATA_WIDTH-1:0] product_full;
  logic [cpfm_pkg::DATA_WIDTH:0]   remainder_shift;
  logic [cpfm_pkg::DATA_WIDTH:0]   trial;

  assign event_stall     = (state != S_IDLE);
  assign accept          = event_valid && !event_stall;
  assign load            = (state == S_OUT) && (!result_valid || !result_stall);
  assign is_capture      = (event_word.action == cpfm_pkg::ACT_CAPTURE_A) ||
                           (event_word.action == cpfm_pkg::ACT_CAPTURE_B);
  assign product_full    = overflow_tally * counter_span;
  assign remainder_shift = {remainder, quotient[cpfm_pkg::DATA_WIDTH-1]};
  assign trial           = remainder_shift - {1'b0, period};

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz     <= cpfm_pkg::CLOCK_HZ_RESET;
      counter_span <= cpfm_pkg::COUNTER_SPAN_RESET;
    end else if (cfg_write) begin
      unique case (cpfm_pkg::reg_index_t'(cfg_index))
        cpfm_pkg::REG_CLOCK_HZ:     clock_hz     <= cfg_data;
        cpfm_pkg::REG_COUNTER_SPAN: counter_span <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer and shared datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      first_capture   <= '0;
      awaiting_second <= 1'b0;
      overflow_tally  <= '0;
      step            <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (event_word.action == cpfm_pkg::ACT_OVERFLOW) begin
              overflow_tally <= overflow_tally + 1'b1;
            end else if (is_capture && !awaiting_second) begin
              first_capture   <= event_word.capture_value;
              overflow_tally  <= '0;
              awaiting_second <= 1'b1;
            end else if (is_capture) begin
              second_capture  <= event_word.capture_value;
              forward         <= (event_word.action == cpfm_pkg::ACT_CAPTURE_A);
              awaiting_second <= 1'b0;
              state           <= S_MUL;
            end
          end
        end
        S_MUL: begin
          span_product   <= product_full[cpfm_pkg::DATA_WIDTH-1:0];
          overflow_tally <= '0;
          state          <= S_SUB;
        end
        S_SUB: begin
          period    <= second_capture + span_product - first_capture;
          remainder <= '0;
          quotient  <= clock_hz;
          step      <= '0;
          state     <= S_DIV;
        end
        S_DIV: begin
          if (!trial[cpfm_pkg::DATA_WIDTH]) begin
            remainder <= trial[cpfm_pkg::DATA_WIDTH-1:0];
            quotient  <= {quotient[cpfm_pkg::DATA_WIDTH-2:0], 1'b1};
          end else begin
            remainder <= remainder_shift[cpfm_pkg::DATA_WIDTH-1:0];
            quotient  <= {quotient[cpfm_pkg::DATA_WIDTH-2:0], 1'b0};
          end
          step <= step + 1'b1;
          if (step == cpfm_pkg::LAST_STEP) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_word.period_counts <= period;
      result_word.frequency     <= (period == '0) ? '0 : quotient;
      result_word.forward       <= forward;
      result_word.divide_error  <= (period == '0);
    end
  end

endmodule

// ===== design/cpfm_checker.sv =====
`timescale 1ns / 1ps

module cpfm_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  event_stall,
  input logic                                  result_valid,
  input logic                                  result_stall,
  input cpfm_pkg::result_word_t                result_word
);

  // no word survives reset
  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result word valid after reset");

  // error flag tracks a zero period
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result_word.divide_error == (result_word.period_counts == '0)))
    else $error("divide_error does not match zero period");

  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_word.divide_error) |-> (result_word.frequency == '0))
    else $error("nonzero frequency on divide error");

  // a new word only comes out of a busy stretch
  assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(event_stall))
    else $error("result word appeared without work in progress");

  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result_word)))
    else $error("stalled result word changed");

endmodule

bind capture_period_frequency_meter_unit cpfm_checker u_cpfm_checker (
  .clk          (clk),
  .rst          (rst),
  .event_stall  (event_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result_word  (result_word)
);
